### src/csad_pkg.sv
// ---------------------------------------------------------------------------
// csad_pkg
// shared types, widths and codes of the cyclic suffix array sorter
// ---------------------------------------------------------------------------
`default_nettype none

package csad_pkg;

    localparam int MAX_LEN = 1024;
    localparam int ADDR_W  = 10;
    localparam int LEN_W   = 11;
    localparam int SYM_W   = 8;
    localparam int CLS_W   = 10;
    localparam int CNT_W   = 11;
    localparam int BUCKETS = 1024;

    localparam logic       OP_LOAD   = 1'b0;
    localparam logic       OP_READ   = 1'b1;
    localparam logic       KIND_DONE = 1'b0;
    localparam logic       KIND_READ = 1'b1;
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_OVF    = 2'd2;

    typedef struct packed {
        logic              opcode;
        logic [SYM_W-1:0]  symbol;
        logic              last_symbol;
        logic [ADDR_W-1:0] rank_index;
    } t_in;

    typedef struct packed {
        logic              kind;
        logic [1:0]        status;
        logic [ADDR_W-1:0] position;
        logic [LEN_W-1:0]  length;
    } t_out;

    typedef struct packed {
        logic [ADDR_W-1:0] text_raddr;
        logic              orda_we;
        logic [ADDR_W-1:0] orda_waddr;
        logic [ADDR_W-1:0] orda_wdata;
        logic [ADDR_W-1:0] orda_raddr;
        logic              ordb_we;
        logic [ADDR_W-1:0] ordb_waddr;
        logic [ADDR_W-1:0] ordb_wdata;
        logic [ADDR_W-1:0] ordb_raddr;
        logic              cls0_we;
        logic              cls1_we;
        logic [ADDR_W-1:0] cls_waddr;
        logic [CLS_W-1:0]  cls_wdata;
        logic [ADDR_W-1:0] cls_raddr;
        logic              cnt_we;
        logic [ADDR_W-1:0] cnt_waddr;
        logic [CNT_W-1:0]  cnt_wdata;
        logic [ADDR_W-1:0] cnt_raddr;
    } t_mem_req;

    typedef enum logic [4:0] {
        SS_IDLE, SS_INIT_RD, SS_INIT_WR, SS_CLR,
        SS_CNT_K, SS_CNT_C, SS_CNT_N, SS_CNT_W,
        SS_PRE_RD, SS_PRE_WR,
        SS_PLC_K, SS_PLC_C, SS_PLC_N, SS_PLC_W,
        SS_LOOP, SS_SHF_RD, SS_SHF_WR,
        SS_REN_A, SS_REN_B, SS_REN_C, SS_REN_D, SS_DONE
    } t_sort_state;

    typedef enum logic [1:0] {
        T_IDLE, T_SORT, T_RD, T_EMIT
    } t_top_state;

endpackage

`default_nettype wire

### src/csad_ram.sv
// ---------------------------------------------------------------------------
// csad_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module csad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### src/csad_sort_ctrl.sv
// ---------------------------------------------------------------------------
// csad_sort_ctrl
// prefix doubling sequencer: radix passes, shift and class renumbering
// ---------------------------------------------------------------------------
`default_nettype none

module csad_sort_ctrl
    import csad_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [LEN_W-1:0]  i_len,
    input  wire logic [SYM_W-1:0]  i_text_rd,
    input  wire logic [ADDR_W-1:0] i_orda_rd,
    input  wire logic [ADDR_W-1:0] i_ordb_rd,
    input  wire logic [CLS_W-1:0]  i_cls0_rd,
    input  wire logic [CLS_W-1:0]  i_cls1_rd,
    input  wire logic [CNT_W-1:0]  i_cnt_rd,
    output t_mem_req               o_req,
    output logic                   o_done
);

    t_sort_state       r_state, n_state;
    logic [LEN_W-1:0]  r_i, n_i, r_n, n_n, r_h, n_h;
    logic [CNT_W-1:0]  r_acc, n_acc;
    logic [ADDR_W-1:0] r_key, n_key;
    logic [CLS_W-1:0]  r_c, n_c, r_ca, n_ca, r_pca, n_pca, r_pcah, n_pcah;
    logic [CLS_W-1:0]  r_cnum, n_cnum;
    logic              r_init, n_init, r_sel, n_sel;

    logic [CLS_W-1:0]  cls_cur, c_new;
    logic [ADDR_W-1:0] key_sel, ah;
    logic [LEN_W-1:0]  ah_sum, v_ext, shifted;
    logic              last_i, last_b, diff;

    assign cls_cur = r_sel ? i_cls1_rd : i_cls0_rd;
    assign key_sel = r_init ? r_i[ADDR_W-1:0] : i_ordb_rd;
    assign last_i  = (r_i == r_n - LEN_W'(1));
    assign last_b  = (r_i == LEN_W'(BUCKETS - 1));
    assign ah_sum  = {1'b0, r_key} + r_h;
    assign ah      = (ah_sum >= r_n) ? ADDR_W'(ah_sum - r_n) : ah_sum[ADDR_W-1:0];
    assign v_ext   = {1'b0, i_orda_rd};
    assign shifted = (v_ext < r_h) ? (v_ext + r_n - r_h) : (v_ext - r_h);
    assign diff    = (r_ca != r_pca) || (cls_cur != r_pcah);
    assign c_new   = (r_i == '0) ? '0 : r_cnum + CLS_W'(diff);
    assign o_done  = (r_state == SS_DONE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            SS_IDLE:    if (i_start) n_state = SS_INIT_RD;
            SS_INIT_RD: n_state = SS_INIT_WR;
            SS_INIT_WR: n_state = last_i ? SS_CLR : SS_INIT_RD;
            SS_CLR:     n_state = last_b ? SS_CNT_K : SS_CLR;
            SS_CNT_K:   n_state = SS_CNT_C;
            SS_CNT_C:   n_state = SS_CNT_N;
            SS_CNT_N:   n_state = SS_CNT_W;
            SS_CNT_W:   n_state = last_i ? SS_PRE_RD : SS_CNT_K;
            SS_PRE_RD:  n_state = SS_PRE_WR;
            SS_PRE_WR:  n_state = last_b ? SS_PLC_K : SS_PRE_RD;
            SS_PLC_K:   n_state = SS_PLC_C;
            SS_PLC_C:   n_state = SS_PLC_N;
            SS_PLC_N:   n_state = SS_PLC_W;
            SS_PLC_W: begin
                if (r_i != '0) n_state = SS_PLC_K;
                else           n_state = r_init ? SS_LOOP : SS_REN_A;
            end
            SS_LOOP:    n_state = (r_h < r_n) ? SS_SHF_RD : SS_DONE;
            SS_SHF_RD:  n_state = SS_SHF_WR;
            SS_SHF_WR:  n_state = last_i ? SS_CLR : SS_SHF_RD;
            SS_REN_A:   n_state = SS_REN_B;
            SS_REN_B:   n_state = SS_REN_C;
            SS_REN_C:   n_state = SS_REN_D;
            SS_REN_D:   n_state = last_i ? SS_LOOP : SS_REN_A;
            SS_DONE:    n_state = SS_IDLE;
            default:    n_state = SS_IDLE;
        endcase
    end

    always_comb begin
        n_i = r_i; n_n = r_n; n_h = r_h; n_acc = r_acc; n_key = r_key; n_c = r_c;
        n_ca = r_ca; n_pca = r_pca; n_pcah = r_pcah; n_cnum = r_cnum;
        n_init = r_init; n_sel = r_sel;
        case (r_state)
            SS_IDLE: begin
                if (i_start) begin
                    n_n = i_len; n_i = '0; n_init = 1'b1; n_sel = 1'b0; n_h = '0;
                end
            end
            SS_INIT_WR, SS_CLR, SS_SHF_WR: begin
                n_i = ((r_state == SS_CLR) ? last_b : last_i) ? '0 : r_i + LEN_W'(1);
            end
            SS_CNT_C, SS_PLC_C: n_key = key_sel;
            SS_CNT_N, SS_PLC_N: n_c = cls_cur;
            SS_CNT_W: begin
                n_i   = last_i ? '0 : r_i + LEN_W'(1);
                n_acc = '0;
            end
            SS_PRE_WR: begin
                n_acc = r_acc + i_cnt_rd;
                n_i   = last_b ? r_n - LEN_W'(1) : r_i + LEN_W'(1);
            end
            SS_PLC_W: begin
                if (r_i != '0) begin
                    n_i = r_i - LEN_W'(1);
                end else begin
                    n_i = '0;
                    if (r_init) begin
                        n_init = 1'b0; n_h = LEN_W'(1);
                    end
                end
            end
            SS_REN_B: n_key = i_orda_rd;
            SS_REN_C: n_ca = cls_cur;
            SS_REN_D: begin
                n_pca = r_ca; n_pcah = cls_cur; n_cnum = c_new;
                if (last_i) begin
                    n_i = '0; n_h = r_h << 1; n_sel = ~r_sel;
                end else begin
                    n_i = r_i + LEN_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_req = '0;
        case (r_state)
            SS_INIT_RD: o_req.text_raddr = r_i[ADDR_W-1:0];
            SS_INIT_WR: begin
                o_req.cls0_we   = ~r_sel;
                o_req.cls1_we   = r_sel;
                o_req.cls_waddr = r_i[ADDR_W-1:0];
                o_req.cls_wdata = CLS_W'(i_text_rd);
            end
            SS_CLR: begin
                o_req.cnt_we    = 1'b1;
                o_req.cnt_waddr = r_i[ADDR_W-1:0];
            end
            SS_CNT_K, SS_PLC_K: o_req.ordb_raddr = r_i[ADDR_W-1:0];
            SS_CNT_C, SS_PLC_C: o_req.cls_raddr = key_sel;
            SS_CNT_N, SS_PLC_N: o_req.cnt_raddr = cls_cur;
            SS_CNT_W: begin
                o_req.cnt_we    = 1'b1;
                o_req.cnt_waddr = r_c;
                o_req.cnt_wdata = i_cnt_rd + CNT_W'(1);
            end
            SS_PRE_RD: o_req.cnt_raddr = r_i[ADDR_W-1:0];
            SS_PRE_WR: begin
                o_req.cnt_we    = 1'b1;
                o_req.cnt_waddr = r_i[ADDR_W-1:0];
                o_req.cnt_wdata = r_acc + i_cnt_rd;
            end
            SS_PLC_W: begin
                o_req.cnt_we     = 1'b1;
                o_req.cnt_waddr  = r_c;
                o_req.cnt_wdata  = i_cnt_rd - CNT_W'(1);
                o_req.orda_we    = 1'b1;
                o_req.orda_waddr = ADDR_W'(i_cnt_rd - CNT_W'(1));
                o_req.orda_wdata = r_key;
            end
            SS_SHF_RD, SS_REN_A: o_req.orda_raddr = r_i[ADDR_W-1:0];
            SS_SHF_WR: begin
                o_req.ordb_we    = 1'b1;
                o_req.ordb_waddr = r_i[ADDR_W-1:0];
                o_req.ordb_wdata = shifted[ADDR_W-1:0];
            end
            SS_REN_B: o_req.cls_raddr = i_orda_rd;
            SS_REN_C: o_req.cls_raddr = ah;
            SS_REN_D: begin
                o_req.cls0_we   = r_sel;
                o_req.cls1_we   = ~r_sel;
                o_req.cls_waddr = r_key;
                o_req.cls_wdata = c_new;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SS_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_i <= n_i; r_n <= n_n; r_h <= n_h; r_acc <= n_acc; r_key <= n_key; r_c <= n_c;
        r_ca <= n_ca; r_pca <= n_pca; r_pcah <= n_pcah; r_cnum <= n_cnum;
        r_init <= n_init; r_sel <= n_sel;
    end

endmodule

`default_nettype wire

### src/cyclic_suffix_array_doubling.sv
// ---------------------------------------------------------------------------
// cyclic_suffix_array_doubling
// sorts all cyclic rotations of a loaded byte string by prefix doubling
//
// the input channel takes one transaction per item: a load stores one symbol,
// and a load marked last_symbol starts the sort; a read asks for the start
// position at a rank. the output channel returns one transaction for a read,
// for an overflowing load and for the end of a sort.
// a non-final load that fits returns nothing and leaves the block idle. a read
// passes through the read and emit states, a rejected read or an overflowing
// load goes straight to the emit state, before the answer is registered.
// a sort of n symbols runs a first bucket pass and then ceil(log2 n)
// doubling rounds; the bucket sweeps over 1024 counters and the several
// passes over the order and class memories set its length.
// one item is worked at a time; input stall is high from the item that
// starts work until its result sits in the output register.
// reset empties the string and clears the sorted flag; memories keep
// their contents. while the receiver stalls, the result is held and the
// block takes the next item once its own result register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module cyclic_suffix_array_doubling
    import csad_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out
);

    t_top_state        r_state, n_state;
    logic [LEN_W-1:0]  r_len, n_len, len_eff;
    logic              r_sorted, n_sorted;
    t_out              r_pend, n_pend, r_out;
    logic              r_out_valid;
    logic              accept, out_free, load_ok, read_ok, start;

    t_mem_req          req;
    logic              sort_done;
    logic [SYM_W-1:0]  text_rd;
    logic [ADDR_W-1:0] orda_rd, ordb_rd, orda_raddr;
    logic [CLS_W-1:0]  cls0_rd, cls1_rd;
    logic [CNT_W-1:0]  cnt_rd;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign len_eff  = r_sorted ? '0 : r_len;
    assign load_ok  = (len_eff < LEN_W'(MAX_LEN));
    assign read_ok  = r_sorted && ({1'b0, i_in.rank_index} < r_len);
    assign start    = accept && (i_in.opcode == OP_LOAD) && i_in.last_symbol;

    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE: begin
                if (accept) begin
                    if (i_in.opcode == OP_READ)  n_state = read_ok ? T_RD : T_EMIT;
                    else if (i_in.last_symbol)   n_state = T_SORT;
                    else if (!load_ok)           n_state = T_EMIT;
                end
            end
            T_SORT:  if (sort_done) n_state = T_EMIT;
            T_RD:    n_state = T_EMIT;
            T_EMIT:  if (out_free) n_state = T_IDLE;
            default: n_state = T_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != T_IDLE);
        orda_raddr = (r_state == T_IDLE) ? i_in.rank_index : req.orda_raddr;
    end

    always_comb begin
        n_len    = r_len;
        n_sorted = r_sorted;
        n_pend   = r_pend;
        case (r_state)
            T_IDLE: begin
                if (accept) begin
                    if (i_in.opcode == OP_READ) begin
                        n_pend.kind     = KIND_READ;
                        n_pend.status   = read_ok ? ST_OK : ST_RANGE;
                        n_pend.position = '0;
                        n_pend.length   = r_len;
                    end else begin
                        n_sorted        = 1'b0;
                        n_len           = load_ok ? len_eff + LEN_W'(1) : len_eff;
                        n_pend.kind     = KIND_DONE;
                        n_pend.status   = load_ok ? ST_OK : ST_OVF;
                        n_pend.position = '0;
                        n_pend.length   = n_len;
                    end
                end
            end
            T_SORT:  if (sort_done) n_sorted = 1'b1;
            T_RD:    n_pend.position = orda_rd;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_len       <= '0;
            r_sorted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_sorted <= n_sorted;
            if (r_state == T_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        r_pend <= n_pend;
        if (r_state == T_EMIT && out_free) begin
            r_out <= r_pend;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    csad_sort_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_len     (n_len),
        .i_text_rd (text_rd),
        .i_orda_rd (orda_rd),
        .i_ordb_rd (ordb_rd),
        .i_cls0_rd (cls0_rd),
        .i_cls1_rd (cls1_rd),
        .i_cnt_rd  (cnt_rd),
        .o_req     (req),
        .o_done    (sort_done)
    );

    csad_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_text (
        .i_clk   (i_clk),
        .i_we    (accept && (i_in.opcode == OP_LOAD) && load_ok),
        .i_waddr (len_eff[ADDR_W-1:0]),
        .i_wdata (i_in.symbol),
        .i_raddr (req.text_raddr),
        .o_rdata (text_rd)
    );

    csad_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_LEN)) u_order_a (
        .i_clk   (i_clk),
        .i_we    (req.orda_we),
        .i_waddr (req.orda_waddr),
        .i_wdata (req.orda_wdata),
        .i_raddr (orda_raddr),
        .o_rdata (orda_rd)
    );

    csad_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_LEN)) u_order_b (
        .i_clk   (i_clk),
        .i_we    (req.ordb_we),
        .i_waddr (req.ordb_waddr),
        .i_wdata (req.ordb_wdata),
        .i_raddr (req.ordb_raddr),
        .o_rdata (ordb_rd)
    );

    csad_ram #(.WIDTH(CLS_W), .DEPTH(MAX_LEN)) u_class_a (
        .i_clk   (i_clk),
        .i_we    (req.cls0_we),
        .i_waddr (req.cls_waddr),
        .i_wdata (req.cls_wdata),
        .i_raddr (req.cls_raddr),
        .o_rdata (cls0_rd)
    );

    csad_ram #(.WIDTH(CLS_W), .DEPTH(MAX_LEN)) u_class_b (
        .i_clk   (i_clk),
        .i_we    (req.cls1_we),
        .i_waddr (req.cls_waddr),
        .i_wdata (req.cls_wdata),
        .i_raddr (req.cls_raddr),
        .o_rdata (cls1_rd)
    );

    csad_ram #(.WIDTH(CNT_W), .DEPTH(BUCKETS)) u_buckets (
        .i_clk   (i_clk),
        .i_we    (req.cnt_we),
        .i_waddr (req.cnt_waddr),
        .i_wdata (req.cnt_wdata),
        .i_raddr (req.cnt_raddr),
        .o_rdata (cnt_rd)
    );

endmodule

`default_nettype wire

### tb/tb_cyclic_suffix_array_doubling.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_cyclic_suffix_array_doubling
// self-checking bench for the cyclic rotation sorter
//
// strings are loaded symbol by symbol and sorted; ranks are then read back
// and compared against a behavioral prefix doubling sorter kept in the
// bench. overflow, early reads, out of range ranks and reloads are covered,
// under random sender and receiver idling.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_cyclic_suffix_array_doubling;
    import csad_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out;

    cyclic_suffix_array_doubling dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // bench copy of the block state
    logic [SYM_W-1:0]  text_mem [MAX_LEN];
    logic [ADDR_W-1:0] rank_to_pos [MAX_LEN];
    int   str_len;
    bit   is_sorted;

    t_out expected_q [$];
    int   errors;
    int   n_sent;
    int   n_checked;
    int   n_sorts;
    int   n_ovf;
    int   n_rangeerr;
    int   send_idle_pct;
    int   recv_idle_pct;
    longint cycle_cnt;

    // prefix doubling over rotations, result in rank_to_pos
    task automatic sort_rotations(input int n);
        int ord [];
        int tmp [];
        int cls [];
        int ncls [];
        int cnt [];
        int h;
        int c;
        int a;
        int b;
        ord  = new[n];
        tmp  = new[n];
        cls  = new[n];
        ncls = new[n];
        cnt  = new[1024];
        for (int i = 0; i < n; i++) begin
            cls[i] = text_mem[i];
            tmp[i] = i;
        end
        foreach (cnt[k]) cnt[k] = 0;
        for (int i = 0; i < n; i++) cnt[cls[tmp[i]]]++;
        for (int k = 1; k < 1024; k++) cnt[k] += cnt[k-1];
        for (int i = n - 1; i >= 0; i--) begin
            cnt[cls[tmp[i]]]--;
            ord[cnt[cls[tmp[i]]]] = tmp[i];
        end
        for (h = 1; h < n; h = h << 1) begin
            for (int i = 0; i < n; i++) tmp[i] = (ord[i] - h + n) % n;
            foreach (cnt[k]) cnt[k] = 0;
            for (int i = 0; i < n; i++) cnt[cls[tmp[i]]]++;
            for (int k = 1; k < 1024; k++) cnt[k] += cnt[k-1];
            for (int i = n - 1; i >= 0; i--) begin
                cnt[cls[tmp[i]]]--;
                ord[cnt[cls[tmp[i]]]] = tmp[i];
            end
            c = 0;
            ncls[ord[0]] = 0;
            for (int i = 1; i < n; i++) begin
                a = ord[i];
                b = ord[i-1];
                if (cls[a] != cls[b] || cls[(a + h) % n] != cls[(b + h) % n]) c++;
                ncls[a] = c;
            end
            for (int i = 0; i < n; i++) cls[i] = ncls[i];
        end
        for (int i = 0; i < n; i++) rank_to_pos[i] = ADDR_W'(ord[i]);
    endtask

    task automatic predict(input t_in it);
        t_out r;
        logic [1:0] st;
        r  = '0;
        st = ST_OK;
        if (it.opcode == OP_READ) begin
            r.kind   = KIND_READ;
            r.length = LEN_W'(str_len);
            if (!is_sorted || int'(it.rank_index) >= str_len) begin
                r.status = ST_RANGE;
                n_rangeerr++;
            end else begin
                r.status   = ST_OK;
                r.position = rank_to_pos[it.rank_index];
            end
            expected_q.push_back(r);
            return;
        end
        if (is_sorted) begin
            is_sorted = 1'b0;
            str_len   = 0;
        end
        if (str_len < MAX_LEN) begin
            text_mem[str_len] = it.symbol;
            str_len++;
        end else begin
            st = ST_OVF;
            n_ovf++;
        end
        if (it.last_symbol) begin
            sort_rotations(str_len);
            is_sorted = 1'b1;
            n_sorts++;
        end else if (st == ST_OK) begin
            return;
        end
        r.kind   = KIND_DONE;
        r.status = st;
        r.length = LEN_W'(str_len);
        expected_q.push_back(r);
    endtask

    // valid stays high between back to back transactions
    task automatic send_item(input t_in it);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict(it);
        n_sent++;
    endtask

    task automatic send_load(input logic [7:0] sym, input logic last);
        t_in it;
        it = '0;
        it.opcode      = OP_LOAD;
        it.symbol      = sym;
        it.last_symbol = last;
        it.rank_index  = 10'($urandom);
        send_item(it);
    endtask

    task automatic send_read(input int rank);
        t_in it;
        it = '0;
        it.opcode     = OP_READ;
        it.rank_index = 10'(rank);
        it.symbol     = 8'($urandom);
        it.last_symbol = 1'($urandom);
        send_item(it);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result %p", $time, o_out);
                errors++;
            end else begin
                t_out e;
                e = expected_q.pop_front();
                if (o_out.kind !== e.kind || o_out.status !== e.status ||
                    o_out.position !== e.position || o_out.length !== e.length) begin
                    $display("%0t mismatch expected %p actual %p", $time, e, o_out);
                    errors++;
                end
                n_checked++;
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > 64'd40_000_000) begin
            $display("timeout");
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic test_directed();
        // read before any sort
        send_read(0);
        send_read(1023);
        // single symbol string
        send_load(8'hff, 1'b1);
        send_read(0);
        send_read(1);
        // all equal symbols, extremes
        for (int i = 0; i < 4; i++) send_load(8'h00, i == 3);
        for (int r = 0; r < 5; r++) send_read(r);
        send_load(8'h5a, 1'b0);
        send_read(0);
        send_load(8'ha5, 1'b1);
        send_read(0);
        send_read(1);
    endtask

    task automatic test_overflow();
        for (int i = 0; i < MAX_LEN + 2; i++) send_load(8'($urandom), 1'b0);
        send_load(8'($urandom), 1'b1);
        send_read(0);
        send_read(1023);
        wait_drained();
    endtask

    task automatic test_random(input int budget);
        int n;
        int reads;
        int alpha;
        while (budget > 0) begin
            n     = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
            alpha = $urandom_range(1, 255);
            if ($urandom_range(9) == 0) send_read($urandom_range(1023));
            for (int i = 0; i < n; i++) begin
                send_load(8'($urandom_range(alpha)) ^ ((alpha > 200) ? 8'h80 : 8'h00),
                          i == n - 1);
            end
            reads = $urandom_range(1, 12);
            for (int r = 0; r < reads; r++)
                send_read(($urandom_range(7) == 0) ? $urandom_range(1023)
                                                   : $urandom_range(n - 1));
            budget -= n + reads;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in          = '0;
        i_out_stall   = 1'b0;
        errors        = 0;
        n_sent        = 0;
        n_checked     = 0;
        n_sorts       = 0;
        n_ovf         = 0;
        n_rangeerr    = 0;
        cycle_cnt     = 0;
        str_len       = 0;
        is_sorted     = 1'b0;
        send_idle_pct = 22;
        recv_idle_pct = 75;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        wait_drained();
        test_overflow();
        test_random(20);
        send_idle_pct = 75;
        recv_idle_pct = 22;
        test_random(20);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(20);

        wait_drained();
        repeat (50) @(posedge i_clk);
        $display("sent %0d transactions, checked %0d results", n_sent, n_checked);
        $display("%0d sorts, %0d overflow reports, %0d rejected reads",
                 n_sorts, n_ovf, n_rangeerr);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
